// ----- hdl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared types and constants for controller and datapath.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic write_texel;
    logic setup;
    logic read_en;
    logic [1:0] read_sel;
    logic capture;
    logic blend_x;
    logic blend_y;
    logic done;
  } ctrl_t;

endpackage

// ----- hdl/bts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler controller
// Sequences texel writes, four neighbor reads, and the blend steps.
// ----------------------------------------------------------------------------
module bts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  output logic          busy,
  output bts_pkg::ctrl_t ctrl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_CAP   = 4'd6;
  localparam logic [3:0] S_BX    = 4'd7;
  localparam logic [3:0] S_BY    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == bts_pkg::OP_SAMPLE) begin
            ctrl.setup = 1'b1;
            state_next = S_SETUP;
          end else begin
            ctrl.write_texel = 1'b1;
          end
        end
      end
      S_SETUP: begin
        ctrl.read_en = 1'b1;
        ctrl.read_sel = 2'd0;
        state_next = S_RD0;
      end
      S_RD0: begin
        ctrl.read_en = 1'b1;
        ctrl.read_sel = 2'd1;
        ctrl.capture = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        ctrl.read_en = 1'b1;
        ctrl.read_sel = 2'd2;
        ctrl.capture = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        ctrl.read_en = 1'b1;
        ctrl.read_sel = 2'd3;
        ctrl.capture = 1'b1;
        state_next = S_RD3;
      end
      S_RD3: begin
        ctrl.capture = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        ctrl.blend_x = 1'b1;
        state_next = S_BX;
      end
      S_BX: begin
        ctrl.blend_y = 1'b1;
        state_next = S_BY;
      end
      S_BY: begin
        ctrl.done = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTH
  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.write_texel |=> state == S_IDLE)
    else $error("write left idle");
  a_setup_reads: assert property (@(posedge clk) disable iff (rst)
    ctrl.setup |=> ctrl.read_en && ctrl.read_sel == 2'd0)
    else $error("setup not followed by read");
  a_done_after_blend: assert property (@(posedge clk) disable iff (rst)
    ctrl.blend_y |=> ctrl.done)
    else $error("blend not followed by done");
`endif

endmodule

// ----- hdl/bts_datapath.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler datapath
// Texel memory, coordinate scaling, edge clamp and two-stage blend.
// ----------------------------------------------------------------------------
module bts_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bts_pkg::ctrl_t        ctrl,
  input  logic [6:0]            texel_x,
  input  logic [6:0]            texel_y,
  input  logic [15:0]           red_in,
  input  logic [15:0]           green_in,
  input  logic [15:0]           blue_in,
  input  logic [15:0]           coord_u,
  input  logic [15:0]           coord_v,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data,
  output logic                  result_valid,
  output logic [15:0]           red_out,
  output logic [15:0]           green_out,
  output logic [15:0]           blue_out
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = (XW > YW ? XW : YW) + 1;
  localparam int CW    = (SW > 8 ? SW : 8);

  logic [7:0] texture_width;
  logic [7:0] texture_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= 8'd128;
      texture_height <= 8'd128;
    end else if (cfg_valid) begin
      if (cfg_index == bts_pkg::CFG_WIDTH) begin
        texture_width <= cfg_data;
      end else begin
        texture_height <= cfg_data;
      end
    end
  end

  // effective sizes
  logic [CW-1:0] wreg;
  logic [CW-1:0] hreg;
  logic [CW-1:0] weff;
  logic [CW-1:0] heff;
  assign wreg = CW'(texture_width);
  assign hreg = CW'(texture_height);
  always_comb begin
    weff = (wreg == '0) ? CW'(1) : wreg;
    if (weff > CW'(MAX_WIDTH)) weff = CW'(MAX_WIDTH);
    heff = (hreg == '0) ? CW'(1) : hreg;
    if (heff > CW'(MAX_HEIGHT)) heff = CW'(MAX_HEIGHT);
  end

  logic [CW+15:0] sx;
  logic [CW+15:0] sy;
  assign sx = (CW+16)'(weff) * (CW+16)'(coord_u);
  assign sy = (CW+16)'(heff) * (CW+16)'(coord_v);

  logic [CW-1:0] x0c;
  logic [CW-1:0] y0c;
  logic [CW-1:0] x1c;
  logic [CW-1:0] y1c;
  always_comb begin
    x0c = sx[CW+15:16];
    if (x0c > weff - CW'(1)) x0c = weff - CW'(1);
    y0c = sy[CW+15:16];
    if (y0c > heff - CW'(1)) y0c = heff - CW'(1);
    x1c = (x0c + CW'(1) < weff) ? x0c + CW'(1) : weff - CW'(1);
    y1c = (y0c + CW'(1) < heff) ? y0c + CW'(1) : heff - CW'(1);
  end

  logic [XW-1:0] x0;
  logic [XW-1:0] x1;
  logic [YW-1:0] y0;
  logic [YW-1:0] y1;
  logic [15:0]   fx;
  logic [15:0]   fy;

  always_ff @(posedge clk) begin
    if (ctrl.setup) begin
      x0 <= x0c[XW-1:0];
      x1 <= x1c[XW-1:0];
      y0 <= y0c[YW-1:0];
      y1 <= y1c[YW-1:0];
      fx <= sx[15:0];
      fy <= sy[15:0];
    end
  end

  // single-port texel memory
  logic [47:0] mem [DEPTH];
  logic [47:0] rdata;
  logic [AW-1:0] addr;
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;
  logic wr_ok;

  always_comb begin
    wx = XW'(texel_x);
    wy = YW'(texel_y);
    wr_ok = (32'(texel_x) < MAX_WIDTH) && (32'(texel_y) < MAX_HEIGHT);
    case (ctrl.read_sel)
      2'd0: addr = {y0, x0};
      2'd1: addr = {y0, x1};
      2'd2: addr = {y1, x0};
      2'd3: addr = {y1, x1};
      default: addr = {y0, x0};
    endcase
    if (ctrl.write_texel) addr = {wy, wx};
  end

  always_ff @(posedge clk) begin
    if (ctrl.write_texel && wr_ok) begin
      mem[addr] <= {red_in, green_in, blue_in};
    end
    if (ctrl.read_en) begin
      rdata <= mem[addr];
    end
  end

  // texel shift line t00, t10, t01, t11
  logic [47:0] tx [4];
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      tx[0] <= tx[1];
      tx[1] <= tx[2];
      tx[2] <= tx[3];
      tx[3] <= rdata;
    end
  end

  logic [15:0] r0 [3];
  logic [15:0] r1 [3];
  logic [15:0] res [3];
  logic [16:0] gx;
  logic [16:0] gy;
  assign gx = 17'h10000 - 17'(fx);
  assign gy = 17'h10000 - 17'(fy);

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [33:0] p0;
    logic [33:0] p1;
    logic [33:0] py;
    assign p0 = 34'(tx[0][47-16*c -: 16]) * 34'(gx) + 34'(tx[1][47-16*c -: 16]) * 34'(fx);
    assign p1 = 34'(tx[2][47-16*c -: 16]) * 34'(gx) + 34'(tx[3][47-16*c -: 16]) * 34'(fx);
    assign py = 34'(r0[c]) * 34'(gy) + 34'(r1[c]) * 34'(fy);
    always_ff @(posedge clk) begin
      if (ctrl.blend_x) begin
        r0[c] <= p0[31:16];
        r1[c] <= p1[31:16];
      end
      if (ctrl.blend_y) begin
        res[c] <= py[31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.done;
    end
  end

  assign red_out   = res[0];
  assign green_out = res[1];
  assign blue_out  = res[2];

`ifndef SYNTH
  a_valid_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");
  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.read_en |-> (32'(x0) < MAX_WIDTH) && (32'(y1) < MAX_HEIGHT))
    else $error("read address out of range");
  a_done_from_blend: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(ctrl.done))
    else $error("result without done");
`endif

endmodule

// ----- hdl/bilinear_texture_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler top level
// Command port, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// A texel write (op 0) leaves busy low. A sample (op 1) keeps busy high
// through four reads of the single-port texel memory and the two blend
// steps; result_strobe pulses for one cycle at the end and must be taken
// then. Configuration is accepted whenever cfg_valid is high and applies
// to the next sample.
module bilinear_texture_sampler_top #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [6:0]  texel_x,
  input  logic [6:0]  texel_y,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] coord_u,
  input  logic [15:0] coord_v,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        result_strobe,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out
);

  bts_pkg::ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  bts_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .busy (busy),
    .ctrl (ctrl)
  );

  bts_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .texel_x     (texel_x),
    .texel_y     (texel_y),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_strobe),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out)
  );

endmodule

// ----- bench/bilinear_texture_sampler_checker.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler checker
// Watches the command, configuration and result ports, keeps its own copy of
// the texture and the size registers, predicts each filtered word and
// compares it with what the block gives.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_checker #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [6:0]  texel_x,
  input  logic [6:0]  texel_y,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] coord_u,
  input  logic [15:0] coord_v,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        result_strobe,
  input  logic [15:0] red_out,
  input  logic [15:0] green_out,
  input  logic [15:0] blue_out,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  rgb_t texels [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [7:0] width_reg, height_reg;
  rgb_t filtered_q [$];

  function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] f);
    return (a * (64'd65536 - f) + b * f) >> 16;
  endfunction

  function automatic logic [15:0] blend4(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                         logic [15:0] d, logic [63:0] fx, logic [63:0] fy);
    logic [63:0] row0, row1, full;
    row0 = lerp16(64'(a), 64'(b), fx);
    row1 = lerp16(64'(c), 64'(d), fx);
    full = lerp16(row0, row1, fy);
    return full[15:0];
  endfunction

  function automatic int clamp_size(logic [7:0] r, int maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return int'(r);
  endfunction

  function automatic rgb_t filter_at(logic [15:0] u, logic [15:0] v);
    int w, h, x0, y0, x1, y1;
    logic [31:0] sx, sy;
    rgb_t t00, t10, t01, t11, res;
    logic [63:0] fx, fy;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    sx = w * u;
    sy = h * v;
    x0 = sx >> 16;
    y0 = sy >> 16;
    fx = 64'(sx[15:0]);
    fy = 64'(sy[15:0]);
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    t00 = texels[y0*MAX_WIDTH + x0];
    t10 = texels[y0*MAX_WIDTH + x1];
    t01 = texels[y1*MAX_WIDTH + x0];
    t11 = texels[y1*MAX_WIDTH + x1];
    res.red   = blend4(t00.red, t10.red, t01.red, t11.red, fx, fy);
    res.green = blend4(t00.green, t10.green, t01.green, t11.green, fx, fy);
    res.blue  = blend4(t00.blue, t10.blue, t01.blue, t11.blue, fx, fy);
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      width_reg  = 8'd128;
      height_reg = 8'd128;
      filtered_q.delete();
    end else begin
      if (result_strobe) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result word r=%0h g=%0h b=%0h", red_out, green_out, blue_out);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (red_out !== want.red) begin
            $error("red_out expected %0h actual %0h", want.red, red_out);
            fail_count++;
          end
          if (green_out !== want.green) begin
            $error("green_out expected %0h actual %0h", want.green, green_out);
            fail_count++;
          end
          if (blue_out !== want.blue) begin
            $error("blue_out expected %0h actual %0h", want.blue, blue_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (op == bts_pkg::OP_WRITE)
          texels[texel_y*MAX_WIDTH + texel_x] = {red_in, green_in, blue_in};
        else
          filtered_q.push_back(filter_at(coord_u, coord_v));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bts_pkg::CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
    end
    pending = filtered_q.size();
  end

endmodule

// ----- bench/bilinear_texture_sampler_top_tb.sv -----
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Drives texel writes and samples under several texture sizes, including
// zero and oversize settings, with random gaps; a separate checker predicts
// every filtered word. Samples only touch texels already written.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_top_tb;

  localparam int MW = 128;
  localparam int MH = 128;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = bts_pkg::OP_WRITE;
  logic [6:0]  texel_x = '0;
  logic [6:0]  texel_y = '0;
  logic [15:0] red_in = '0, green_in = '0, blue_in = '0;
  logic [15:0] coord_u = '0, coord_v = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = bts_pkg::CFG_WIDTH;
  logic [7:0]  cfg_data = '0;
  logic        result_strobe;
  logic [15:0] red_out, green_out, blue_out;
  int          fail_count, pending;

  bit          written [0:MW*MH-1];
  logic [7:0]  cur_w, cur_h;
  bit          no_gaps;
  int          n_items, n_samples, n_cfg;

  always #6 clk = ~clk;

  bilinear_texture_sampler_top #(.MAX_WIDTH(MW), .MAX_HEIGHT(MH)) dut (.*);

  bilinear_texture_sampler_checker #(.MAX_WIDTH(MW), .MAX_HEIGHT(MH)) checker_i (.*);

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic issue(logic o, logic [6:0] x, logic [6:0] y, logic [15:0] r,
                       logic [15:0] g, logic [15:0] b, logic [15:0] u, logic [15:0] v);
    int gap;
    start <= 1'b1;
    op <= o;
    texel_x <= x; texel_y <= y;
    red_in <= r; green_in <= g; blue_in <= b;
    coord_u <= u; coord_v <= v;
    do @(posedge clk); while (busy);
    n_items++;
    if (o == bts_pkg::OP_WRITE) written[y*MW + x] = 1'b1;
    else n_samples++;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 1)) begin
      gap = ($urandom_range(0, 29) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_rand(logic [6:0] x, logic [6:0] y);
    issue(bts_pkg::OP_WRITE, x, y, 16'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic set_size(logic [7:0] w, logic [7:0] h);
    drain();
    cfg_valid <= 1'b1; cfg_index <= bts_pkg::CFG_WIDTH; cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= bts_pkg::CFG_HEIGHT; cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_w = w; cur_h = h;
    n_cfg++;
  endtask

  // fill any unwritten neighbor, then sample
  task automatic sample(logic [15:0] u, logic [15:0] v);
    int w, h, x0, y0, x1, y1;
    w = (cur_w == 0) ? 1 : (cur_w > MW) ? MW : cur_w;
    h = (cur_h == 0) ? 1 : (cur_h > MH) ? MH : cur_h;
    x0 = (w * u) >> 16; y0 = (h * v) >> 16;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    if (!written[y0*MW + x0]) write_rand(7'(x0), 7'(y0));
    if (!written[y0*MW + x1]) write_rand(7'(x1), 7'(y0));
    if (!written[y1*MW + x0]) write_rand(7'(x0), 7'(y1));
    if (!written[y1*MW + x1]) write_rand(7'(x1), 7'(y1));
    issue(bts_pkg::OP_SAMPLE, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), u, v);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] sizes_w [7] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd2, 8'd129, 8'd127};
    logic [7:0] sizes_h [7] = '{8'd128, 8'd1, 8'd0, 8'd200, 8'd3, 8'd128, 8'd64};
    n_items = 0; n_samples = 0; n_cfg = 0;
    no_gaps = 1'b0;
    cur_w = 8'd128; cur_h = 8'd128;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme texels and coordinates at reset size, then at sizes 1, 0 and 255
    issue(bts_pkg::OP_WRITE, 7'd0, 7'd0, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'hffff);
    issue(bts_pkg::OP_WRITE, 7'd1, 7'd0, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    issue(bts_pkg::OP_WRITE, 7'd127, 7'd127, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0);
    issue(bts_pkg::OP_WRITE, 7'd0, 7'd0, 16'hffff, 16'hffff, 16'hffff, 16'h1234, 16'h5678);
    sample(16'h0000, 16'h0000);
    sample(16'hffff, 16'hffff);
    sample(16'h0080, 16'h0000);
    sample(16'h8000, 16'h8000);
    sample(16'hffff, 16'h0000);
    set_size(8'd1, 8'd1);
    sample(16'hffff, 16'hffff);
    set_size(8'd0, 8'd0);
    sample(16'h8000, 16'h4000);
    set_size(8'd255, 8'd255);
    sample(16'hffff, 16'hffff);
    sample(16'h0001, 16'h7fff);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 7) set_size(sizes_w[ph], sizes_h[ph]);
      else set_size(8'($urandom), 8'($urandom));
      no_gaps = (ph % 4 == 3);
      for (int i = 0; i < 45; i++) begin
        if ($urandom_range(0, 2) == 0) write_rand(7'($urandom), 7'($urandom));
        else sample(rand_coord(), rand_coord());
        if (i == 22 && ph == 2) drain();
      end
    end

    drain();
    $display("covered %0d words (%0d samples) over %0d size settings",
             n_items, n_samples, n_cfg);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
